// ===== rtl/fmfr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fmfr_pkg: shared definitions for the feature map filter response block
// Store sizes, word types, opcodes, register indexes and the state type.
// ---------------------------------------------------------------------------
package fmfr_pkg;

   localparam int MAP_DEPTH    = 65536;
   localparam int FILTER_DEPTH = 4096;
   localparam int SAMPLE_BITS  = 16;
   localparam int ACC_BITS     = 48;
   localparam int RESP_BITS    = 48;

   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int FILTER_AW = $clog2(FILTER_DEPTH);

   typedef logic        [MAP_AW-1:0]        map_addr_type;
   typedef logic        [FILTER_AW-1:0]     filt_addr_type;
   typedef logic signed [SAMPLE_BITS-1:0]   word_type;
   typedef logic signed [2*SAMPLE_BITS-1:0] prod_type;
   typedef logic signed [ACC_BITS-1:0]      acc_type;
   typedef logic signed [ACC_BITS:0]        acc_sum_type;
   typedef logic signed [63:0]              wide_type;
   typedef logic signed [RESP_BITS-1:0]     resp_type;

   localparam wide_type RESP_MAX = wide_type'((64'sd1 <<< (RESP_BITS - 1)) - 64'sd1);
   localparam wide_type RESP_MIN = -RESP_MAX - 64'sd1;

   localparam logic [1:0] OP_LOAD_MAP    = 2'd0;
   localparam logic [1:0] OP_LOAD_FILTER = 2'd1;
   localparam logic [1:0] OP_COMPUTE     = 2'd2;

   localparam logic [2:0] CSR_MAP_HEIGHT    = 3'd0;
   localparam logic [2:0] CSR_MAP_WIDTH     = 3'd1;
   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [2:0] CSR_FILTER_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_FILTER_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_SUMMED_MODE   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIZE,
      ST_START,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/feature_map_filter_response.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// feature_map_filter_response: valid-region multichannel filter response
// Map samples and filter coefficients are held in two synchronous memories;
// a compute word walks the filter window with one multiply-accumulate a cycle.
// ---------------------------------------------------------------------------
// A load word is written to its store as it is accepted. A compute word walks
// FH*FW*N taps (N = channel_count in summed mode, else 1): setup in ST_CHECK,
// ST_SIZE and ST_START, one tap a cycle, a drain of the multiply-accumulate
// pipeline and an output step; an invalid position skips the walk. One word is
// in work at a time; an unread result word holds the next compute's result back.
// Synchronous reset restores the register defaults; the stores are not cleared.
module feature_map_filter_response (
   input  wire         clock,
   input  wire         reset,
   // configuration write port
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [6:0]  csr_wdata,
   // request words
   input  wire         req_tvalid,
   output logic        req_tready,
   // store_index[15:0], sample_value[31:16], out_row[37:32], out_col[43:38],
   // out_channel[48:44], zero fill [55:49]
   input  wire  [55:0] req_tdata,
   // opcode[1:0]
   input  wire  [1:0]  req_tuser,
   // response words
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // response[47:0]
   output logic [47:0] rsp_tdata,
   // position_valid[0]
   output logic        rsp_tuser
);

   // configuration registers
   logic [6:0] map_height_ff, map_width_ff;
   logic [5:0] channel_count_ff, filter_height_ff, filter_width_ff;
   logic       summed_mode_ff;

   // request fields
   logic [1:0]         req_opcode;
   logic [15:0]        req_index;
   logic signed [15:0] req_value;
   logic [5:0]         req_row, req_col;
   logic [4:0]         req_channel;
   logic               req_accept;

   // stores
   fmfr_pkg::word_type map_mem [fmfr_pkg::MAP_DEPTH];
   fmfr_pkg::word_type filt_mem [fmfr_pkg::FILTER_DEPTH];
   logic               map_we, filt_we;
   fmfr_pkg::word_type wr_word;
   fmfr_pkg::word_type map_rd_ff, filt_rd_ff;

   // control and setup
   fmfr_pkg::state_type state_ff, state_in;
   logic [5:0]  row_ff, row_in, col_ff, col_in;
   logic [4:0]  ch_ff, ch_in;
   logic        basic_ok_ff, basic_ok_in, ok_ff, ok_in;
   logic [13:0] plane_ff, plane_in, off_ff, off_in;
   logic [11:0] fplane_ff, fplane_in;
   logic [19:0] mtot_ff, mtot_in;
   logic [17:0] ftot_ff, ftot_in;
   logic [18:0] mbase_ff, mbase_in;

   // window walk
   fmfr_pkg::map_addr_type  chan_base_ff, chan_base_in;
   fmfr_pkg::map_addr_type  map_col_ff, map_col_in;
   fmfr_pkg::map_addr_type  map_addr_ff, map_addr_in;
   fmfr_pkg::filt_addr_type filt_addr_ff, filt_addr_in;
   logic [5:0] i_ff, i_in, j_ff, j_in, c_ff, c_in;
   logic       last_row, last_col, last_chan, issue_vld, issue_last;

   // multiply-accumulate pipeline
   logic               rd_vld_ff, rd_last_ff, prod_vld_ff, prod_last_ff;
   fmfr_pkg::prod_type prod_ff;
   fmfr_pkg::acc_type  acc_ff, acc_in;
   fmfr_pkg::acc_sum_type acc_sum;
   fmfr_pkg::acc_type  acc_sat;
   fmfr_pkg::wide_type acc_wide;
   fmfr_pkg::resp_type resp_clamped;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_flag_ff, rsp_flag_in;

   assign req_opcode  = req_tuser;
   assign req_index   = req_tdata[15:0];
   assign req_value   = req_tdata[31:16];
   assign req_row     = req_tdata[37:32];
   assign req_col     = req_tdata[43:38];
   assign req_channel = req_tdata[48:44];

   assign req_tready = (state_ff == fmfr_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign wr_word = fmfr_pkg::word_type'(req_value);
   assign map_we  = req_accept && (req_opcode == fmfr_pkg::OP_LOAD_MAP) &&
                    (32'(req_index) < fmfr_pkg::MAP_DEPTH);
   assign filt_we = req_accept && (req_opcode == fmfr_pkg::OP_LOAD_FILTER) &&
                    (32'(req_index) < fmfr_pkg::FILTER_DEPTH);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_height_ff    <= 7'd64;
         map_width_ff     <= 7'd64;
         channel_count_ff <= 6'd1;
         filter_height_ff <= 6'd1;
         filter_width_ff  <= 6'd1;
         summed_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            fmfr_pkg::CSR_MAP_HEIGHT:    map_height_ff    <= csr_wdata;
            fmfr_pkg::CSR_MAP_WIDTH:     map_width_ff     <= csr_wdata;
            fmfr_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[5:0];
            fmfr_pkg::CSR_FILTER_HEIGHT: filter_height_ff <= csr_wdata[5:0];
            fmfr_pkg::CSR_FILTER_WIDTH:  filter_width_ff  <= csr_wdata[5:0];
            fmfr_pkg::CSR_SUMMED_MODE:   summed_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // map store: one write port for loads, one registered read port for the walk
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[fmfr_pkg::map_addr_type'(req_index)] <= wr_word;
      end
      map_rd_ff <= map_mem[map_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (filt_we) begin
         filt_mem[fmfr_pkg::filt_addr_type'(req_index)] <= wr_word;
      end
      filt_rd_ff <= filt_mem[filt_addr_ff];
   end

   // window position flags
   assign last_row  = ((i_ff + 6'd1) == filter_height_ff);
   assign last_col  = ((j_ff + 6'd1) == filter_width_ff);
   assign last_chan = !summed_mode_ff || ((c_ff + 6'd1) == channel_count_ff);
   assign issue_vld  = (state_ff == fmfr_pkg::ST_RUN);
   assign issue_last = issue_vld && last_row && last_col && last_chan;

   // saturating accumulate
   always_comb begin
      acc_sum = fmfr_pkg::acc_sum_type'(acc_ff) + fmfr_pkg::acc_sum_type'(prod_ff);
      if (acc_sum[fmfr_pkg::ACC_BITS] != acc_sum[fmfr_pkg::ACC_BITS-1]) begin
         acc_sat = acc_sum[fmfr_pkg::ACC_BITS]
                   ? {1'b1, {(fmfr_pkg::ACC_BITS-1){1'b0}}}
                   : {1'b0, {(fmfr_pkg::ACC_BITS-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[fmfr_pkg::ACC_BITS-1:0];
      end
      acc_wide = fmfr_pkg::wide_type'(acc_ff);
      if (acc_wide > fmfr_pkg::RESP_MAX) begin
         resp_clamped = fmfr_pkg::resp_type'(fmfr_pkg::RESP_MAX);
      end else if (acc_wide < fmfr_pkg::RESP_MIN) begin
         resp_clamped = fmfr_pkg::resp_type'(fmfr_pkg::RESP_MIN);
      end else begin
         resp_clamped = fmfr_pkg::resp_type'(acc_wide);
      end
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ch_in        = ch_ff;
      basic_ok_in  = basic_ok_ff;
      ok_in        = ok_ff;
      plane_in     = plane_ff;
      fplane_in    = fplane_ff;
      off_in       = off_ff;
      mtot_in      = mtot_ff;
      ftot_in      = ftot_ff;
      mbase_in     = mbase_ff;
      chan_base_in = chan_base_ff;
      map_col_in   = map_col_ff;
      map_addr_in  = map_addr_ff;
      filt_addr_in = filt_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;

      if (prod_vld_ff) begin
         acc_in = acc_sat;
      end

      case (state_ff)
         fmfr_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == fmfr_pkg::OP_COMPUTE)) begin
               row_in   = req_row;
               col_in   = req_col;
               ch_in    = req_channel;
               state_in = fmfr_pkg::ST_CHECK;
            end
         end
         fmfr_pkg::ST_CHECK: begin
            basic_ok_in = (map_height_ff != 7'd0) && (map_width_ff != 7'd0) &&
                          (channel_count_ff != 6'd0) && (filter_height_ff != 6'd0) &&
                          (filter_width_ff != 6'd0) &&
                          ({1'b0, filter_height_ff} <= map_height_ff) &&
                          ({1'b0, filter_width_ff} <= map_width_ff) &&
                          ((7'(row_ff) + 7'(filter_height_ff)) <= map_height_ff) &&
                          ((7'(col_ff) + 7'(filter_width_ff)) <= map_width_ff) &&
                          (summed_mode_ff || (6'(ch_ff) < channel_count_ff));
            plane_in  = 14'(map_height_ff) * 14'(map_width_ff);
            fplane_in = 12'(filter_height_ff) * 12'(filter_width_ff);
            off_in    = 14'(col_ff) * 14'(map_height_ff) + 14'(row_ff);
            state_in  = fmfr_pkg::ST_SIZE;
         end
         fmfr_pkg::ST_SIZE: begin
            mtot_in  = 20'(plane_ff) * 20'(channel_count_ff);
            ftot_in  = 18'(fplane_ff) * 18'(channel_count_ff);
            mbase_in = 19'(plane_ff) * 19'(ch_ff);
            state_in = fmfr_pkg::ST_START;
         end
         fmfr_pkg::ST_START: begin
            ok_in = basic_ok_ff && (32'(mtot_ff) <= fmfr_pkg::MAP_DEPTH) &&
                    (summed_mode_ff ? (32'(ftot_ff) <= fmfr_pkg::FILTER_DEPTH)
                                    : (32'(fplane_ff) <= fmfr_pkg::FILTER_DEPTH));
            chan_base_in = summed_mode_ff ? '0 : fmfr_pkg::map_addr_type'(mbase_ff);
            map_col_in   = chan_base_in + fmfr_pkg::map_addr_type'(off_ff);
            map_addr_in  = map_col_in;
            filt_addr_in = '0;
            i_in         = 6'd0;
            j_in         = 6'd0;
            c_in         = 6'd0;
            acc_in       = '0;
            state_in     = ok_in ? fmfr_pkg::ST_RUN : fmfr_pkg::ST_DONE;
         end
         fmfr_pkg::ST_RUN: begin
            // Filter taps lie back to back in the store, so its address just counts.
            filt_addr_in = filt_addr_ff + 12'd1;
            if (!last_row) begin
               i_in        = i_ff + 6'd1;
               map_addr_in = map_addr_ff + 16'd1;
            end else begin
               i_in = 6'd0;
               if (!last_col) begin
                  j_in        = j_ff + 6'd1;
                  map_col_in  = map_col_ff + fmfr_pkg::map_addr_type'(map_height_ff);
                  map_addr_in = map_col_in;
               end else begin
                  j_in = 6'd0;
                  if (!last_chan) begin
                     c_in         = c_ff + 6'd1;
                     chan_base_in = chan_base_ff + fmfr_pkg::map_addr_type'(plane_ff);
                     map_col_in   = chan_base_in + fmfr_pkg::map_addr_type'(off_ff);
                     map_addr_in  = map_col_in;
                  end else begin
                     state_in = fmfr_pkg::ST_DRAIN;
                  end
               end
            end
         end
         fmfr_pkg::ST_DRAIN: begin
            if (prod_vld_ff && prod_last_ff) begin
               state_in = fmfr_pkg::ST_DONE;
            end
         end
         fmfr_pkg::ST_DONE: begin
            // Waits here while an earlier result word is still unread.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ok_ff ? 48'(resp_clamped) : 48'd0;
               rsp_flag_in  = ok_ff;
               state_in     = fmfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmfr_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= issue_vld;
         rd_last_ff   <= issue_last;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      ch_ff        <= ch_in;
      basic_ok_ff  <= basic_ok_in;
      ok_ff        <= ok_in;
      plane_ff     <= plane_in;
      fplane_ff    <= fplane_in;
      off_ff       <= off_in;
      mtot_ff      <= mtot_in;
      ftot_ff      <= ftot_in;
      mbase_ff     <= mbase_in;
      chan_base_ff <= chan_base_in;
      map_col_ff   <= map_col_in;
      map_addr_ff  <= map_addr_in;
      filt_addr_ff <= filt_addr_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      c_ff         <= c_in;
      prod_ff      <= map_rd_ff * filt_rd_ff;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

`default_nettype wire
